>>> sv/mpts_pkg.sv
// ---------------------------------------------------------------------------
// Minimap pixel tone and sharpen package
// Shared constants, codes, and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mpts_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 10;
    localparam int VAL_W      = 20;
    localparam int DIV_STEPS  = 19;
    localparam int DIV_CNT_W  = 5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LINE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_BOOST_GAIN  = 3'd1;
    localparam logic [2:0] CFG_CONTRAST    = 3'd2;
    localparam logic [2:0] CFG_BRIGHTNESS  = 3'd3;
    localparam logic [2:0] CFG_SHARPEN_EN  = 3'd4;
    localparam logic [2:0] CFG_SHARPEN_AMT = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_VB,
        ST_MUL_DEN,
        ST_DEN,
        ST_CHK,
        ST_DIV,
        ST_CON,
        ST_ADD,
        ST_EMIT1,
        ST_EMIT2,
        ST_FSUM,
        ST_FMUL1,
        ST_FMUL2,
        ST_FOUT,
        ST_PFIN,
        ST_FLCHK,
        ST_FLR0,
        ST_FLR1,
        ST_FLR2,
        ST_FLR3,
        ST_FLFIN
    } state_t;

    typedef enum logic [2:0] {
        MUL_VB,
        MUL_DEN,
        MUL_CON,
        MUL_CEN,
        MUL_NB
    } mul_sel_t;

    typedef enum logic [1:0] {
        RD_PIX,
        RD_FM1,
        RD_F0,
        RD_FP1
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     num_ld;
        logic     den_ld;
        logic     div_init;
        logic     div_step;
        logic     tone_ld;
        logic     wk_first;
        logic     wk_second;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     cap_en;
        logic [1:0] cap_col;
        logic     wk_flush;
        logic     sum_ld;
        logic     p1_ld;
        logic     out_ld;
        logic     pos_pixel;
        logic     pos_flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_flush;
        logic flush_ignore;
        logic div_skip;
        logic div_done;
        logic emit_first;
        logic emit_second;
        logic out_free;
    } stat_t;

endpackage

>>> sv/minimap_pixel_tone_sharpen.sv
// ---------------------------------------------------------------------------
// Minimap pixel tone and sharpen
// Tone maps raster depth pixels and applies an optional 3x3 sharpen.
// ---------------------------------------------------------------------------
// One request is taken at a time: the next request can be accepted only once
// the previous one has finished. A pixel request produces no result, one
// result or two results. Most of its time goes to the 19-step boost divider;
// when the boost saturates or its denominator is not positive the divider is
// skipped. A flush request either emits a result or is ignored and emits
// nothing. Results wait in an output register, and a result only stalls the
// block when the next one is ready before the previous has been taken. The
// line store needs no clearing pass after reset.
module minimap_pixel_tone_sharpen import mpts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_depth_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel_byte,
    output logic        m_last_of_run,
    output logic        m_end_of_frame
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    mpts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic, storage and output register.
    mpts_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_opcode       (s_opcode),
        .s_depth_value  (s_depth_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_byte   (m_pixel_byte),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_frame (m_end_of_frame),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

>>> sv/mpts_ctrl.sv
// ---------------------------------------------------------------------------
// Minimap pixel tone and sharpen controller
// Sequences tone mapping, divider steps, store accesses and filter results.
// ---------------------------------------------------------------------------
module mpts_ctrl import mpts_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    // State and result phase registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FLCHK;
                end
            end
            ST_FLCHK: begin
                if (!stat.op_flush) begin
                    state_next = ST_MUL_VB;
                end else if (stat.flush_ignore) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_FLR0;
                end
            end
            ST_MUL_VB:  state_next = ST_MUL_DEN;
            ST_MUL_DEN: state_next = ST_DEN;
            ST_DEN:     state_next = ST_CHK;
            ST_CHK:     state_next = stat.div_skip ? ST_CON : ST_DIV;
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_CON;
                end
            end
            ST_CON: state_next = ST_ADD;
            ST_ADD: state_next = ST_EMIT1;
            ST_EMIT1: begin
                if (stat.emit_first) begin
                    phase_next = 1'b0;
                    state_next = ST_FSUM;
                end else if (stat.emit_second) begin
                    phase_next = 1'b1;
                    state_next = ST_FSUM;
                end else begin
                    state_next = ST_PFIN;
                end
            end
            ST_EMIT2: begin
                phase_next = 1'b1;
                state_next = ST_FSUM;
            end
            ST_FSUM:  state_next = ST_FMUL1;
            ST_FMUL1: state_next = ST_FMUL2;
            ST_FMUL2: state_next = ST_FOUT;
            ST_FOUT: begin
                if (stat.out_free) begin
                    if (stat.op_flush) begin
                        state_next = ST_FLFIN;
                    end else if (!phase_reg && stat.emit_second) begin
                        state_next = ST_EMIT2;
                    end else begin
                        state_next = ST_PFIN;
                    end
                end
            end
            ST_PFIN:  state_next = ST_IDLE;
            ST_FLR0:  state_next = ST_FLR1;
            ST_FLR1:  state_next = ST_FLR2;
            ST_FLR2:  state_next = ST_FLR3;
            ST_FLR3:  state_next = ST_FSUM;
            ST_FLFIN: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd       = '0;
        cmd.mul_sel = MUL_VB;
        cmd.rd_sel  = RD_PIX;
        s_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_MUL_VB: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_VB;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_PIX;
            end
            ST_MUL_DEN: begin
                cmd.num_ld  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEN;
            end
            ST_DEN:  cmd.den_ld   = 1'b1;
            ST_CHK:  cmd.div_init = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_CON: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CON;
            end
            ST_ADD:  cmd.tone_ld = 1'b1;
            ST_EMIT1: begin
                cmd.wk_first  = stat.emit_first;
                cmd.wk_second = !stat.emit_first && stat.emit_second;
            end
            ST_EMIT2: cmd.wk_second = 1'b1;
            ST_FSUM:  cmd.sum_ld = 1'b1;
            ST_FMUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CEN;
            end
            ST_FMUL2: begin
                cmd.p1_ld   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NB;
            end
            ST_FOUT:  cmd.out_ld = stat.out_free;
            ST_PFIN:  cmd.pos_pixel = 1'b1;
            ST_FLR0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_FM1;
            end
            ST_FLR1: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_col = 2'd0;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_F0;
            end
            ST_FLR2: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_col = 2'd1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_FP1;
            end
            ST_FLR3: begin
                cmd.cap_en   = 1'b1;
                cmd.cap_col  = 2'd2;
                cmd.wk_flush = 1'b1;
            end
            ST_FLFIN: cmd.pos_flush = 1'b1;
            ST_FLCHK: ;
            default: ;
        endcase
    end

endmodule

>>> sv/mpts_dp.sv
// ---------------------------------------------------------------------------
// Minimap pixel tone and sharpen datapath
// Configuration, tone arithmetic, line store, 3x3 window and output register.
// ---------------------------------------------------------------------------
module mpts_dp import mpts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_opcode,
    input  logic [15:0] s_depth_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel_byte,
    output logic        m_last_of_run,
    output logic        m_end_of_frame,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Configuration registers.
    logic [WIDTH_W-1:0] lw_reg;
    logic [15:0]        boost_reg, con_reg, bri_reg, samt_reg;
    logic               sen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg    <= WIDTH_W'(MAX_WIDTH);
            boost_reg <= 16'd256;
            con_reg   <= 16'd256;
            bri_reg   <= 16'd0;
            sen_reg   <= 1'b0;
            samt_reg  <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:  lw_reg    <= cfg_wr_data[WIDTH_W-1:0];
                CFG_BOOST_GAIN:  boost_reg <= cfg_wr_data;
                CFG_CONTRAST:    con_reg   <= cfg_wr_data;
                CFG_BRIGHTNESS:  bri_reg   <= cfg_wr_data;
                CFG_SHARPEN_EN:  sen_reg   <= cfg_wr_data[0];
                CFG_SHARPEN_AMT: samt_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Effective width, clamped column and flush positions.
    logic [WIDTH_W-1:0] w_eff, wm1, c_full, f_full;
    logic [ADDR_W-1:0]  col_reg, c_idx, f_idx;
    logic [15:0]        row_reg;
    logic [WIDTH_W-1:0] flush_reg;
    logic               c_last, f_last;

    always_comb begin
        if (lw_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (lw_reg > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = lw_reg;
        end
        wm1    = w_eff - WIDTH_W'(1);
        c_full = ({1'b0, col_reg} >= w_eff) ? wm1 : {1'b0, col_reg};
        f_full = (flush_reg >= w_eff) ? wm1 : flush_reg;
        c_idx  = c_full[ADDR_W-1:0];
        f_idx  = f_full[ADDR_W-1:0];
        c_last = (c_full == wm1);
        f_last = (f_full == wm1);
    end

    // Latched input request.
    logic        op_reg;
    logic [15:0] v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= 1'b0;
        end else if (cmd.accept) begin
            op_reg <= s_opcode;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            v_reg <= s_depth_value;
        end
    end

    // Position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            flush_reg <= '0;
        end else if (cmd.accept && !s_opcode && flush_reg != '0) begin
            col_reg   <= '0;
            row_reg   <= '0;
            flush_reg <= '0;
        end else if (cmd.pos_pixel) begin
            if (c_last) begin
                col_reg <= '0;
                if (row_reg != 16'hFFFF) begin
                    row_reg <= row_reg + 16'd1;
                end
            end else begin
                col_reg <= c_idx + ADDR_W'(1);
            end
        end else if (cmd.pos_flush) begin
            if (f_last) begin
                col_reg   <= '0;
                row_reg   <= '0;
                flush_reg <= '0;
            end else begin
                flush_reg <= f_full + WIDTH_W'(1);
            end
        end
    end

    // Shared multiplier with a registered product.
    logic [15:0]        s_eff;
    logic signed [23:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [44:0] prod_reg;
    logic [16:0]        bm;
    logic signed [VAL_W-1:0] t_reg;
    logic signed [23:0] nb_reg;
    logic signed [VAL_W-1:0] wk_reg [3][3];

    assign s_eff = sen_reg ? samt_reg : 16'd0;
    assign bm    = {1'b0, boost_reg} - 17'd256;

    always_comb begin
        case (cmd.mul_sel)
            MUL_VB: begin
                mul_a = {8'd0, v_reg};
                mul_b = {5'd0, boost_reg};
            end
            MUL_DEN: begin
                mul_a = {{7{bm[16]}}, bm};
                mul_b = {5'd0, v_reg};
            end
            MUL_CON: begin
                mul_a = {{4{t_reg[VAL_W-1]}}, t_reg};
                mul_b = {{5{con_reg[15]}}, con_reg};
            end
            MUL_CEN: begin
                mul_a = {{4{wk_reg[1][1][VAL_W-1]}}, wk_reg[1][1]};
                mul_b = 21'({s_eff, 3'b000}) + 21'd4096;
            end
            MUL_NB: begin
                mul_a = nb_reg;
                mul_b = {5'd0, s_eff};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Boost division: saturation check, then one quotient bit per cycle.
    logic [46:0]        num_reg;
    logic signed [34:0] den_reg;
    logic [32:0]        rem_reg;
    logic [18:0]        lo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [33:0]        rem2;
    logic               den_bad, num_sat;

    assign den_bad = den_reg[34] || (den_reg == '0);
    assign num_sat = {6'd0, num_reg} >= {den_reg[33:0], 19'd0};
    assign rem2    = {rem_reg, lo_reg[18]};

    always_ff @(posedge aclk) begin
        if (cmd.num_ld) begin
            num_reg <= {prod_reg[31:0], 15'd0};
        end
        if (cmd.den_ld) begin
            den_reg <= prod_reg[34:0] + 35'sd8388608;
        end
        if (cmd.div_init) begin
            rem_reg <= {5'd0, num_reg[46:19]};
            lo_reg  <= num_reg[18:0];
            cnt_reg <= '0;
            t_reg   <= (den_bad || num_sat) ? VAL_MAX : '0;
        end else if (cmd.div_step) begin
            if (rem2 >= den_reg[33:0]) begin
                rem_reg <= 33'(rem2 - den_reg[33:0]);
                t_reg   <= {t_reg[VAL_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem2[32:0];
                t_reg   <= {t_reg[VAL_W-2:0], 1'b0};
            end
            lo_reg  <= {lo_reg[17:0], 1'b0};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Contrast and brightness with saturation.
    logic signed [45:0] u_wide;
    logic signed [VAL_W-1:0] u_val;

    always_comb begin
        u_wide = 46'(prod_reg >>> 8) + 46'($signed(bri_reg) * 46'sd8);
        if (u_wide > 46'(VAL_MAX)) begin
            u_val = VAL_MAX;
        end else if (u_wide < 46'(VAL_MIN)) begin
            u_val = VAL_MIN;
        end else begin
            u_val = u_wide[VAL_W-1:0];
        end
    end

    // Line store: previous row in the upper half, current row in the lower.
    logic [2*VAL_W-1:0] mem [MAX_WIDTH];
    logic [2*VAL_W-1:0] memq_reg;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb begin
        case (cmd.rd_sel)
            RD_PIX:  rd_addr = c_idx;
            RD_FM1:  rd_addr = f_idx - ADDR_W'(1);
            RD_F0:   rd_addr = f_idx;
            RD_FP1:  rd_addr = f_idx + ADDR_W'(1);
            default: rd_addr = c_idx;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            memq_reg <= mem[rd_addr];
        end
        if (cmd.tone_ld) begin
            mem[c_idx] <= {memq_reg[VAL_W-1:0], u_val};
        end
    end

    // Sliding window and the work window fed to the filter.
    logic signed [VAL_W-1:0] win_reg [3][3];
    logic fl_up_reg, fl_down_reg, fl_left_reg, fl_right_reg, last_reg, end_reg;
    logic col_ok;

    always_comb begin
        case (cmd.cap_col)
            2'd0:    col_ok = (f_idx != '0);
            2'd2:    col_ok = ({1'b0, f_full} + 11'd1) < {1'b0, w_eff};
            default: col_ok = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.tone_ld) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= memq_reg[2*VAL_W-1:VAL_W];
            win_reg[1][2] <= memq_reg[VAL_W-1:0];
            win_reg[2][2] <= u_val;
        end
        if (cmd.wk_first) begin
            wk_reg       <= win_reg;
            fl_up_reg    <= row_reg >= 16'd2;
            fl_down_reg  <= 1'b1;
            fl_left_reg  <= c_idx >= ADDR_W'(2);
            fl_right_reg <= 1'b1;
            last_reg     <= !c_last;
            end_reg      <= 1'b0;
        end else if (cmd.wk_second) begin
            for (int i = 0; i < 3; i++) begin
                wk_reg[i][0] <= win_reg[i][1];
                wk_reg[i][1] <= win_reg[i][2];
                wk_reg[i][2] <= '0;
            end
            fl_up_reg    <= row_reg >= 16'd2;
            fl_down_reg  <= 1'b1;
            fl_left_reg  <= c_idx >= ADDR_W'(1);
            fl_right_reg <= 1'b0;
            last_reg     <= 1'b1;
            end_reg      <= 1'b0;
        end else begin
            if (cmd.cap_en) begin
                wk_reg[0][cmd.cap_col] <= col_ok ? memq_reg[2*VAL_W-1:VAL_W] : '0;
                wk_reg[1][cmd.cap_col] <= col_ok ? memq_reg[VAL_W-1:0] : '0;
                wk_reg[2][cmd.cap_col] <= '0;
            end
            if (cmd.wk_flush) begin
                fl_up_reg    <= row_reg >= 16'd2;
                fl_down_reg  <= 1'b0;
                fl_left_reg  <= f_idx != '0;
                fl_right_reg <= !f_last;
                last_reg     <= 1'b1;
                end_reg      <= f_last;
            end
        end
    end

    // Neighbor sum over the present neighbors.
    logic signed [23:0] nb_sum;

    always_comb begin
        nb_sum = '0;
        if (fl_left_reg)  nb_sum = nb_sum + 24'(wk_reg[1][0]);
        if (fl_right_reg) nb_sum = nb_sum + 24'(wk_reg[1][2]);
        if (fl_up_reg)    nb_sum = nb_sum + 24'(wk_reg[0][1]);
        if (fl_down_reg)  nb_sum = nb_sum + 24'(wk_reg[2][1]);
        if (fl_left_reg && fl_up_reg)    nb_sum = nb_sum + 24'(wk_reg[0][0]);
        if (fl_left_reg && fl_down_reg)  nb_sum = nb_sum + 24'(wk_reg[2][0]);
        if (fl_right_reg && fl_up_reg)   nb_sum = nb_sum + 24'(wk_reg[0][2]);
        if (fl_right_reg && fl_down_reg) nb_sum = nb_sum + 24'(wk_reg[2][2]);
    end

    logic signed [44:0] p1_reg;
    logic signed [45:0] acc;
    logic [7:0]         byte_val;

    always_ff @(posedge aclk) begin
        if (cmd.sum_ld) begin
            nb_reg <= nb_sum;
        end
        if (cmd.p1_ld) begin
            p1_reg <= prod_reg;
        end
    end

    // Clamp the filter result to a byte.
    always_comb begin
        acc = 46'(p1_reg) - 46'(prod_reg);
        if (acc <= 0) begin
            byte_val = 8'd0;
        end else if (|acc[45:27]) begin
            byte_val = 8'd255;
        end else begin
            byte_val = acc[26:19];
        end
    end

    // Output register.
    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic       olast_reg, oend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            byte_reg  <= byte_val;
            olast_reg <= last_reg;
            oend_reg  <= end_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_byte   = byte_reg;
    assign m_last_of_run  = olast_reg;
    assign m_end_of_frame = oend_reg;

    // Status toward the controller.
    always_comb begin
        stat.op_flush     = op_reg;
        stat.flush_ignore = (col_reg != '0) || (row_reg == '0);
        stat.div_skip     = den_bad || num_sat;
        stat.div_done     = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        stat.emit_first   = (row_reg != '0) && (c_idx != '0);
        stat.emit_second  = (row_reg != '0) && c_last;
        stat.out_free     = !m_valid_reg || m_ready;
    end

endmodule

>>> sv/mpts_checker.sv
// ---------------------------------------------------------------------------
// Minimap pixel tone and sharpen port checker
// Checks port behavior over time; bound to the top level.
// ---------------------------------------------------------------------------
module mpts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_pixel_byte,
    input logic       m_last_of_run,
    input logic       m_end_of_frame
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_byte))
        else $error("result changed while stalled");

    // The end of a frame is always the last result of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_last_of_run)
        else $error("end of frame without last of run");

    // No result appears right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A request is worked on alone: input is closed the cycle after accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back to back cycles");

endmodule

bind minimap_pixel_tone_sharpen mpts_checker u_mpts_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_pixel_byte   (m_pixel_byte),
    .m_last_of_run  (m_last_of_run),
    .m_end_of_frame (m_end_of_frame)
);
